// File: design/sun_incidence_angles_assert.svh
// Assertion macros for the sun incidence angle block.
`ifndef SUN_INCIDENCE_ANGLES_ASSERT_SVH
`define SUN_INCIDENCE_ANGLES_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define SIA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sia assertion failed");

// next-cycle implication
`define SIA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sia assertion failed");

`endif

// File: design/sia_pkg.sv
// Shared constants, tables and arithmetic helpers for the sun incidence angle block.
package sia_pkg;

	localparam int ANGLE_FRAC_BITS = 7;
	localparam int CORDIC_STAGES   = 18;

	localparam int INW  = 16;
	localparam int VW   = 32;
	localparam int CW   = 34;
	localparam int ZW   = 34;
	localparam int XW   = 36;
	localparam int AW   = 40;
	localparam int UW   = 16;
	localparam int ONW  = 35;
	localparam int MULW = 2 * XW - 30;

	localparam int TURN_UNITS = 360 * (2 ** ANGLE_FRAC_BITS);
	localparam int HALF_UNITS = 180 * (2 ** ANGLE_FRAC_BITS);

	localparam int CONV_SH  = 29 - ANGLE_FRAC_BITS;
	localparam int RECIP45  = 46604;
	localparam int RECIP_SH = 21;
	localparam int QA_W     = 2 * INW - RECIP_SH;

	localparam int SQRT_STAGES = 32;
	localparam int LAT_SC   = CORDIC_STAGES + 3;
	localparam int LAT_MATH = 8;
	localparam int LAT_AC   = CORDIC_STAGES + SQRT_STAGES + 2;
	localparam int LAT      = LAT_SC + LAT_MATH + LAT_AC + 1;

	localparam logic signed [CW-1:0] GAIN_Q30     = CW'(652032874);
	localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(longint'(1) << 30);
	localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(longint'(1) << 31);

	typedef enum logic {
		REG_TILT    = 1'b0,
		REG_AZIMUTH = 1'b1
	} reg_idx_t;

	typedef logic [31:0] frac_tbl_t [45];

	function automatic frac_tbl_t make_frac_tbl();
		frac_tbl_t t;
		for (int i = 0; i < 45; i++) begin
			t[i] = 32'(((longint'(i) << CONV_SH) + 22) / 45);
		end
		return t;
	endfunction

	localparam frac_tbl_t FRAC_TBL = make_frac_tbl();

	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] v;
		case (i)
			0:  v = 32'h20000000;
			1:  v = 32'h12E4051E;
			2:  v = 32'h09FB385B;
			3:  v = 32'h051111D4;
			4:  v = 32'h028B0D43;
			5:  v = 32'h0145D7E1;
			6:  v = 32'h00A2F61E;
			7:  v = 32'h00517C55;
			8:  v = 32'h0028BE53;
			9:  v = 32'h00145F2F;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2FA;
			15: v = 32'h0000517D;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A30;
			19: v = 32'h00000518;
			20: v = 32'h0000028C;
			21: v = 32'h00000146;
			22: v = 32'h000000A3;
			23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

	// Q2.30 product, rounded half up
	function automatic logic signed [MULW-1:0] mul30(input logic signed [XW-1:0] a,
		input logic signed [XW-1:0] b);
		logic signed [2*XW-1:0] p;
		p = (2 * XW)'(a) * (2 * XW)'(b);
		p = p + (2 * XW)'(longint'(1) << 29);
		return MULW'(p >>> 30);
	endfunction

endpackage

// File: design/sia_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
module sia_sqrt_cell (
	input  logic                            clk,
	input  logic                            en,
	input  logic [4:0]                      idx,
	input  logic [63:0]                     rem_in,
	input  logic [63:0]                     res_in,
	input  logic signed [sia_pkg::XW-1:0]   x_in,
	output logic [63:0]                     rem_out,
	output logic [63:0]                     res_out,
	output logic signed [sia_pkg::XW-1:0]   x_out
);

	logic [63:0] bit_v;
	logic [63:0] sum;
	logic        ge;

	assign bit_v = 64'd1 << (6'd62 - {idx, 1'b0});
	assign sum   = res_in + bit_v;
	assign ge    = rem_in >= sum;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= ge ? rem_in - sum : rem_in;
			res_out <= ge ? (res_in >> 1) + bit_v : res_in >> 1;
			x_out   <= x_in;
		end
	end

endmodule

// File: design/sia_vec_cell.sv
// One vectoring CORDIC cell.
module sia_vec_cell (
	input  logic                            clk,
	input  logic                            en,
	input  logic [4:0]                      idx,
	input  logic signed [sia_pkg::AW-1:0]   x_in,
	input  logic signed [sia_pkg::AW-1:0]   y_in,
	input  logic signed [sia_pkg::ZW-1:0]   z_in,
	output logic signed [sia_pkg::AW-1:0]   x_out,
	output logic signed [sia_pkg::AW-1:0]   y_out,
	output logic signed [sia_pkg::ZW-1:0]   z_out
);

	logic signed [sia_pkg::ZW-1:0] a_v;

	assign a_v = sia_pkg::ZW'(sia_pkg::atan_turn(int'(idx)));

	always_ff @(posedge clk) begin
		if (en) begin
			if (y_in > 0) begin
				x_out <= x_in + (y_in >>> idx);
				y_out <= y_in - (x_in >>> idx);
				z_out <= z_in + a_v;
			end else begin
				x_out <= x_in - (y_in >>> idx);
				y_out <= y_in + (x_in >>> idx);
				z_out <= z_in - a_v;
			end
		end
	end

endmodule

// File: design/sia_sincos.sv
// Angle to binary-angle conversion and rotation CORDIC chain giving cosine and sine.
module sia_sincos (
	input  logic                            clk,
	input  logic                            en,
	input  logic [sia_pkg::INW-1:0]         angle,
	output logic signed [sia_pkg::VW-1:0]   cos_v,
	output logic signed [sia_pkg::VW-1:0]   sin_v
);

	localparam int N = sia_pkg::CORDIC_STAGES;

	logic [2*sia_pkg::INW-1:0]  prod_s1;
	logic [sia_pkg::INW-1:0]    ang_s1;
	logic [31:0]                bin_s2;
	logic [sia_pkg::QA_W-1:0]   qa;
	logic [5:0]                 ra;
	logic [31:0]                bin;
	logic signed [sia_pkg::ZW-1:0] zs;

	logic signed [sia_pkg::CW-1:0] x_s [N+1];
	logic signed [sia_pkg::CW-1:0] y_s [N+1];
	logic signed [sia_pkg::ZW-1:0] z_s [N+1];
	logic                          flip_s [N+1];

	assign qa  = prod_s1[2*sia_pkg::INW-1:sia_pkg::RECIP_SH];
	assign ra  = 6'(ang_s1 - sia_pkg::INW'(qa) * sia_pkg::INW'(6'd45));
	assign bin = (32'(qa) << sia_pkg::CONV_SH) + sia_pkg::FRAC_TBL[ra];
	assign zs  = sia_pkg::ZW'(signed'(bin_s2));

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= (2 * sia_pkg::INW)'(angle) * (2 * sia_pkg::INW)'(sia_pkg::RECIP45);
			ang_s1  <= angle;
			bin_s2  <= bin;
			x_s[0]  <= sia_pkg::GAIN_Q30;
			y_s[0]  <= '0;
			if (zs > sia_pkg::QUARTER_TURN) begin
				z_s[0]    <= zs - sia_pkg::HALF_TURN;
				flip_s[0] <= 1'b1;
			end else if (zs < -sia_pkg::QUARTER_TURN) begin
				z_s[0]    <= zs + sia_pkg::HALF_TURN;
				flip_s[0] <= 1'b1;
			end else begin
				z_s[0]    <= zs;
				flip_s[0] <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		localparam logic signed [sia_pkg::ZW-1:0] A = sia_pkg::ZW'(sia_pkg::atan_turn(i));
		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - A;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + A;
				end
			end
		end
	end

	assign cos_v = sia_pkg::VW'(flip_s[N] ? -x_s[N] : x_s[N]);
	assign sin_v = sia_pkg::VW'(flip_s[N] ? -y_s[N] : y_s[N]);

endmodule

// File: design/sia_acos.sv
// Arc cosine as atan2(sqrt(r), x): square root cell chain, then vectoring CORDIC chain.
module sia_acos (
	input  logic                            clk,
	input  logic                            en,
	input  logic [63:0]                     rad,
	input  logic signed [sia_pkg::XW-1:0]   xin,
	output logic [sia_pkg::UW-1:0]          units
);

	localparam int N = sia_pkg::CORDIC_STAGES;
	localparam int Q = sia_pkg::SQRT_STAGES;

	logic [63:0]                   rem_c [Q+1];
	logic [63:0]                   res_c [Q+1];
	logic signed [sia_pkg::XW-1:0] xs_c  [Q+1];

	logic signed [sia_pkg::AW-1:0] vx [N+1];
	logic signed [sia_pkg::AW-1:0] vy [N+1];
	logic signed [sia_pkg::ZW-1:0] vz [N+1];

	logic signed [sia_pkg::AW-1:0] yr;
	logic signed [sia_pkg::AW-1:0] xe;
	logic [31:0]                   zc;
	logic [47:0]                   prod;

	assign rem_c[0] = rad;
	assign res_c[0] = '0;
	assign xs_c[0]  = xin;

	for (genvar i = 0; i < Q; i++) begin : g_sqrt
		sia_sqrt_cell u_cell (
			.clk     (clk),
			.en      (en),
			.idx     (5'(i)),
			.rem_in  (rem_c[i]),
			.res_in  (res_c[i]),
			.x_in    (xs_c[i]),
			.rem_out (rem_c[i+1]),
			.res_out (res_c[i+1]),
			.x_out   (xs_c[i+1])
		);
	end

	assign yr = sia_pkg::AW'(res_c[Q][32:0]);
	assign xe = sia_pkg::AW'(xs_c[Q]);

	always_ff @(posedge clk) begin
		if (en) begin
			if (xe < 0) begin
				vx[0] <= yr;
				vy[0] <= -xe;
				vz[0] <= sia_pkg::QUARTER_TURN;
			end else begin
				vx[0] <= xe;
				vy[0] <= yr;
				vz[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_vec
		sia_vec_cell u_cell (
			.clk   (clk),
			.en    (en),
			.idx   (5'(i)),
			.x_in  (vx[i]),
			.y_in  (vy[i]),
			.z_in  (vz[i]),
			.x_out (vx[i+1]),
			.y_out (vy[i+1]),
			.z_out (vz[i+1])
		);
	end

	always_comb begin
		if (vz[N] < 0) begin
			zc = '0;
		end else if (vz[N] > sia_pkg::HALF_TURN) begin
			zc = 32'(sia_pkg::HALF_TURN);
		end else begin
			zc = 32'(vz[N]);
		end
	end

	assign prod = 48'(zc) * 48'(sia_pkg::TURN_UNITS);

	always_ff @(posedge clk) begin
		if (en) begin
			units <= sia_pkg::UW'((prod + 48'(longint'(1) << 31)) >> 32);
		end
	end

endmodule

// File: design/sun_incidence_angles.sv
// Top level: incidence and in-plane angles of the sun on a tilted panel.
//
//  port group   dir   handshake              payload
//  in           in    in_valid / in_stall    zenith, azimuth
//  out          out   out_valid / out_stall  incidence_angle, in_plane_angle, along_normal
//  cfg          in    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word per cycle while out_stall does not freeze the pipe; the latency is set by
// the 32-cell square root chain and the two CORDIC cell chains.
// Reset: tilt 4736, azimuth 23040, pipeline empty.
// out_stall on a waiting word freezes the whole pipe and raises in_stall.
// cfg_ready is always high.
module sun_incidence_angles (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [14:0] zenith,
	input  logic [15:0] azimuth,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [14:0] incidence_angle,
	output logic [15:0] in_plane_angle,
	output logic        along_normal,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	`include "sun_incidence_angles_assert.svh"

	localparam int L   = sia_pkg::LAT;
	localparam int LA  = sia_pkg::LAT_AC;
	localparam int VW  = sia_pkg::VW;
	localparam int XW  = sia_pkg::XW;
	localparam int ONW = sia_pkg::ONW;

	logic [13:0]  tilt_q;
	logic [15:0]  azim_q;
	logic [L-1:0] vld_q;
	logic         en;

	logic signed [VW-1:0] ct, st, ca, sa, cz, sz, cs, ss;

	logic signed [VW-1:0] n0_s1, n1_s1, s0_s1, s1_s1, ct_s1, st_s1, cz_s1;
	logic signed [VW-1:0] d0_s2, d1_s2, d2_s2;
	logic signed [VW-1:0] n0_s2, n1_s2, s0_s2, s1_s2, ct_s2, st_s2, cz_s2;
	logic signed [33:0]   dot_s3;
	logic signed [VW-1:0] n0_s3, n1_s3, s0_s3, s1_s3, ct_s3, st_s3, cz_s3;
	logic signed [ONW-1:0] on0_s4, on1_s4, on2_s4;
	logic signed [VW-1:0] ct_s4, st_s4, c_s4;
	logic [63:0]          rth_s4;
	logic [63:0]          sq0_s5, sq1_s5, sq2_s5, rth_s5;
	logic signed [XW-1:0] pm0_s5, pm2_s5;
	logic                 neg_s5, neg_s6, neg_s7, neg_s8;
	logic signed [VW-1:0] c_s5, c_s6, c_s7, c_s8;
	logic [63:0]          m2_s6, rth_s6, m2_s7, p2_s7, rth_s7, rth_s8, rph_s8;
	logic signed [XW-1:0] p_s6, p_s7, p_s8;
	logic                 near_s7, near_s8;
	logic signed [VW-1:0] c_clamp;

	logic                 near_d [LA];
	logic                 neg_d  [LA];
	logic [sia_pkg::UW-1:0] th_units, ph_units;

	function automatic logic [63:0] square64(input logic signed [XW-1:0] v);
		logic signed [2*XW-1:0] p;
		p = (2 * XW)'(v) * (2 * XW)'(v);
		return p[63:0];
	endfunction

	assign en        = !(vld_q[L-1] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[L-1];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_q <= 14'd4736;
			azim_q <= 16'd23040;
			vld_q  <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					sia_pkg::REG_TILT:    tilt_q <= cfg_data[13:0];
					sia_pkg::REG_AZIMUTH: azim_q <= cfg_data;
					default: ;
				endcase
			end
			if (en) begin
				vld_q <= {vld_q[L-2:0], in_valid};
			end
		end
	end

	sia_sincos u_sc_tilt (.clk(clk), .en(en), .angle(16'(tilt_q)), .cos_v(ct), .sin_v(st));
	sia_sincos u_sc_azim (.clk(clk), .en(en), .angle(azim_q), .cos_v(ca), .sin_v(sa));
	sia_sincos u_sc_zen  (.clk(clk), .en(en), .angle(16'(zenith)), .cos_v(cz), .sin_v(sz));
	sia_sincos u_sc_saz  (.clk(clk), .en(en), .angle(azimuth), .cos_v(cs), .sin_v(ss));

	always_comb begin
		if (dot_s3 > 34'sd1073741824) begin
			c_clamp = VW'(34'sd1073741824);
		end else if (dot_s3 < -34'sd1073741824) begin
			c_clamp = VW'(-34'sd1073741824);
		end else begin
			c_clamp = VW'(dot_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// unit vectors
			n0_s1 <= VW'(sia_pkg::mul30(XW'(st), XW'(ca)));
			n1_s1 <= VW'(sia_pkg::mul30(XW'(st), XW'(sa)));
			s0_s1 <= VW'(sia_pkg::mul30(XW'(sz), XW'(cs)));
			s1_s1 <= VW'(sia_pkg::mul30(XW'(sz), XW'(ss)));
			ct_s1 <= ct;
			st_s1 <= st;
			cz_s1 <= cz;
			// dot product terms
			d0_s2 <= VW'(sia_pkg::mul30(XW'(n0_s1), XW'(s0_s1)));
			d1_s2 <= VW'(sia_pkg::mul30(XW'(n1_s1), XW'(s1_s1)));
			d2_s2 <= VW'(sia_pkg::mul30(XW'(ct_s1), XW'(cz_s1)));
			n0_s2 <= n0_s1;
			n1_s2 <= n1_s1;
			s0_s2 <= s0_s1;
			s1_s2 <= s1_s1;
			ct_s2 <= ct_s1;
			st_s2 <= st_s1;
			cz_s2 <= cz_s1;
			dot_s3 <= 34'(d0_s2) + 34'(d1_s2) + 34'(d2_s2);
			n0_s3 <= n0_s2;
			n1_s3 <= n1_s2;
			s0_s3 <= s0_s2;
			s1_s3 <= s1_s2;
			ct_s3 <= ct_s2;
			st_s3 <= st_s2;
			cz_s3 <= cz_s2;
			// projection onto the panel plane
			on0_s4 <= ONW'(s0_s3) - ONW'(sia_pkg::mul30(XW'(dot_s3), XW'(n0_s3)));
			on1_s4 <= ONW'(s1_s3) - ONW'(sia_pkg::mul30(XW'(dot_s3), XW'(n1_s3)));
			on2_s4 <= ONW'(cz_s3) - ONW'(sia_pkg::mul30(XW'(dot_s3), XW'(ct_s3)));
			ct_s4  <= ct_s3;
			st_s4  <= st_s3;
			c_s4   <= c_clamp;
			rth_s4 <= (64'd1 << 60) - square64(XW'(c_clamp));
			sq0_s5 <= square64(XW'(on0_s4));
			sq1_s5 <= square64(XW'(on1_s4));
			sq2_s5 <= square64(XW'(on2_s4));
			pm0_s5 <= XW'(sia_pkg::mul30(XW'(on0_s4), XW'(ct_s4)));
			pm2_s5 <= XW'(sia_pkg::mul30(XW'(on2_s4), XW'(st_s4)));
			neg_s5 <= on1_s4 < 0;
			c_s5   <= c_s4;
			rth_s5 <= rth_s4;
			m2_s6  <= sq0_s5 + sq1_s5 + sq2_s5;
			p_s6   <= pm0_s5 + pm2_s5;
			neg_s6 <= neg_s5;
			c_s6   <= c_s5;
			rth_s6 <= rth_s5;
			m2_s7  <= m2_s6;
			p2_s7  <= square64(p_s6);
			near_s7 <= m2_s6 < 64'h1_0000_0000;
			p_s7   <= p_s6;
			neg_s7 <= neg_s6;
			c_s7   <= c_s6;
			rth_s7 <= rth_s6;
			rph_s8 <= (m2_s7 > p2_s7) ? m2_s7 - p2_s7 : 64'd0;
			near_s8 <= near_s7;
			p_s8   <= p_s7;
			neg_s8 <= neg_s7;
			c_s8   <= c_s7;
			rth_s8 <= rth_s7;
		end
	end

	sia_acos u_ac_theta (
		.clk   (clk),
		.en    (en),
		.rad   (rth_s8),
		.xin   (XW'(c_s8)),
		.units (th_units)
	);

	sia_acos u_ac_phi (
		.clk   (clk),
		.en    (en),
		.rad   (rph_s8),
		.xin   (p_s8),
		.units (ph_units)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			near_d[0] <= near_s8;
			neg_d[0]  <= neg_s8;
			for (int k = 1; k < LA; k++) begin
				near_d[k] <= near_d[k-1];
				neg_d[k]  <= neg_d[k-1];
			end
			incidence_angle <= th_units[14:0];
			along_normal    <= near_d[LA-1];
			if (near_d[LA-1]) begin
				in_plane_angle <= '0;
			end else if (neg_d[LA-1]) begin
				in_plane_angle <= 16'(sia_pkg::TURN_UNITS) - ph_units;
			end else begin
				in_plane_angle <= ph_units;
			end
		end
	end

	`SIA_ASSERT_NEXT(a_freeze, out_valid && out_stall, $stable(vld_q))
	`SIA_ASSERT_NOW(a_normal_zero, out_valid && along_normal, in_plane_angle == 16'd0)
	`SIA_ASSERT_NOW(a_theta_max, out_valid, incidence_angle <= 15'(sia_pkg::HALF_UNITS))
	`SIA_ASSERT_NOW(a_phi_max, out_valid, in_plane_angle <= 16'(sia_pkg::TURN_UNITS))
	`SIA_ASSERT_NEXT(a_cfg_tilt, cfg_valid && cfg_index == sia_pkg::REG_TILT,
		tilt_q == $past(cfg_data[13:0]))

endmodule
